// ===== src/best_fit_heap_allocator_unit_defines.svh =====
// Assertion macros used by the allocator's controller (bfa_ctrl).
// No dependencies; guarded against double inclusion.
`ifndef BEST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH
`define BEST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define BFA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BFA_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFA_ASSERT(label, clk, rst_n, prop, msg)
`define BFA_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== src/bfa_pkg.sv =====
// Shared types and codes for the best-fit heap allocator.
// No dependencies.
package bfa_pkg;
	localparam logic [1:0] ST_ALLOC = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_FREED = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture request, init scan
		logic scan;      // examine entry at scan index
		logic map_rd;    // issue map read for free
		logic map_cap;   // capture map read data
		logic look;      // fetch neighbors at insert index
		logic apply;     // update entries / start shift
		logic shift;     // one shift step
		logic finish;    // present result
	} bfa_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_free;
		logic scan_done;
		logic bad_off;
		logic need_shift;
		logic shift_done;
	} bfa_stat_t;
endpackage

// ===== src/bfa_ram.sv =====
// Generic single-port-write, registered-read RAM.
// No dependencies.
module bfa_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ===== src/bfa_ctrl.sv =====
// Controller state machine of the allocator: sequences scan, map access,
// merge and table shift. Depends on bfa_pkg and the assertion macros.
`include "best_fit_heap_allocator_unit_defines.svh"
module bfa_ctrl import bfa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  bfa_stat_t st,
	output bfa_cmd_t  cmd
);
	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_MAPRD, S_MAPCAP, S_LOOK, S_APPLY, S_SHIFT, S_DONE
	} state_t;

	state_t state_q;

	always_comb begin
		cmd = '0;
		cmd.load = start && !busy;
		case (state_q)
			S_SCAN:   cmd.scan = 1'b1;
			S_MAPRD:  cmd.map_rd = 1'b1;
			S_MAPCAP: cmd.map_cap = 1'b1;
			S_LOOK:   cmd.look = 1'b1;
			S_APPLY:  cmd.apply = 1'b1;
			S_SHIFT:  cmd.shift = 1'b1;
			S_DONE:   cmd.finish = 1'b1;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (start) begin
					state_q <= S_MAPRD;
					busy <= 1'b1;
				end
				S_MAPRD: state_q <= st.is_free ? S_MAPCAP : S_SCAN;
				S_MAPCAP: state_q <= st.bad_off ? S_DONE : S_SCAN;
				S_SCAN: if (st.scan_done) state_q <= st.is_free ? S_LOOK : S_APPLY;
				S_LOOK: state_q <= S_APPLY;
				S_APPLY: state_q <= st.need_shift ? S_SHIFT : S_DONE;
				S_SHIFT: if (st.shift_done) state_q <= S_DONE;
				S_DONE: begin
					state_q <= S_IDLE;
					busy <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy <= 1'b0;
				end
			endcase
		end
	end

	`BFA_ASSERT(a_busy_idle, clk, arst_n, (state_q == S_IDLE) |-> !busy, "busy in idle")
	`BFA_ASSERT(a_done_one, clk, arst_n, (state_q == S_DONE) |=> (state_q == S_IDLE), "done stuck")
	`BFA_ASSERT(a_start_busy, clk, arst_n, (start && !busy) |=> busy, "start not taken")
endmodule

// ===== src/bfa_dp.sv =====
// Datapath of the allocator: extent table, scan registers, block size map.
// Depends on bfa_pkg and bfa_ram.
module bfa_dp import bfa_pkg::*; #(
	parameter int ARENA_BYTES  = 4096,
	parameter int ALIGN_BYTES  = 8,
	parameter int HEADER_BYTES = 8,
	parameter int MAX_EXTENTS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  bfa_cmd_t    cmd,
	output bfa_stat_t   st,
	input  logic        req_type,
	input  logic [12:0] alloc_bytes,
	input  logic [11:0] free_offset,
	output logic        done,
	output logic [1:0]  status,
	output logic [11:0] payload_offset
);
	localparam int AW   = $clog2(ARENA_BYTES) + 1;   // room for sums
	localparam int HDR  = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
	localparam int ALB  = $clog2(ALIGN_BYTES);
	localparam int MAPD = ARENA_BYTES / ALIGN_BYTES;
	localparam int MAW  = $clog2(MAPD);
	localparam int IW   = $clog2(MAX_EXTENTS);
	localparam int CW   = $clog2(MAX_EXTENTS + 1);
	localparam int SW   = AW + 2;
	localparam logic [AW-1:0] HDR_W  = AW'(HDR);
	localparam logic [AW-1:0] ENDM_W = AW'(ARENA_BYTES - HDR);

	logic [AW-1:0] start_q [MAX_EXTENTS];
	logic [AW-1:0] pay_q   [MAX_EXTENTS];
	logic [CW-1:0] count_q;

	logic          is_free_q;
	logic          bad_q;
	logic [SW-1:0] total_q;
	logic [AW-1:0] fs_q, sz_q;
	logic [CW-1:0] idx_q;       // scan index
	logic [IW-1:0] pick_q;
	logic          found_q, stop_q;
	logic [AW-1:0] pick_pay_q;
	logic [AW-1:0] up_st_q, up_pay_q, dn_st_q, dn_pay_q;
	logic [CW-1:0] sh_q;        // shift cursor
	logic          sh_dir_q;    // 1 = open gap, 0 = close gap
	logic [CW-1:0] sh_end_q;
	logic [1:0]    res_st_q;
	logic [11:0]   res_off_q;
	logic          done_q;

	logic [SW-1:0] need;
	logic [AW-1:0] fs_c;
	logic [IW-1:0] idx_i;
	logic          in_range;
	logic [MAW-1:0] map_waddr, map_raddr;
	logic          map_we;
	logic [11:0]   map_rdata;
	logic          bad_c;
	logic          up_c, dn_c;

	assign need  = SW'(alloc_bytes) + SW'(HDR + ALIGN_BYTES - 1);
	assign fs_c  = AW'(free_offset) - HDR_W;
	assign bad_c = (AW'(free_offset) < HDR_W) || (fs_c >= ENDM_W);
	assign idx_i = idx_q[IW-1:0];
	assign in_range = idx_q < count_q;

	// map: indexed by header offset / ALIGN
	assign map_raddr = MAW'(fs_q >> ALB);
	assign map_we    = cmd.apply && !is_free_q && found_q && (start_q[pick_q] < AW'(ARENA_BYTES));
	assign map_waddr = MAW'(start_q[pick_q] >> ALB);

	bfa_ram #(.WIDTH(12), .DEPTH(MAPD)) u_map (
		.clk(clk), .we(map_we), .waddr(map_waddr),
		.wdata(12'(total_q - SW'(HDR))), .raddr(map_raddr), .rdata(map_rdata)
	);

	assign up_c = (idx_q < count_q) && (fs_q + HDR_W + sz_q == up_st_q);
	assign dn_c = (idx_q != '0) && (dn_st_q + HDR_W + dn_pay_q == fs_q);

	assign st.is_free    = is_free_q;
	assign st.bad_off    = bad_q;
	assign st.scan_done  = !in_range || stop_q;
	assign st.need_shift = is_free_q && ((up_c && dn_c) ||
		(!up_c && !dn_c && count_q < CW'(MAX_EXTENTS) && idx_q < count_q));
	// open gap ends with the step that drops the new extent in
	assign st.shift_done = sh_dir_q ? (sh_q == CW'(sh_end_q + 1'b1)) :
		(CW'(sh_q + 1'b1) >= sh_end_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_EXTENTS; k++) begin
				start_q[k] <= '0;
				pay_q[k] <= (k == 0) ? AW'(ARENA_BYTES - 2 * HDR) : '0;
			end
			count_q <= CW'(1);
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.apply && !is_free_q && found_q) begin
				start_q[pick_q] <= start_q[pick_q] + AW'(total_q);
				pay_q[pick_q] <= pay_q[pick_q] - AW'(total_q);
			end
			if (cmd.apply && is_free_q) begin
				if (up_c && dn_c) begin
					pay_q[idx_i-1'b1] <= dn_pay_q + HDR_W + sz_q + HDR_W + up_pay_q;
					count_q <= count_q - 1'b1;
				end else if (up_c) begin
					start_q[idx_i] <= fs_q;
					pay_q[idx_i] <= up_pay_q + HDR_W + sz_q;
				end else if (dn_c) begin
					pay_q[idx_i-1'b1] <= dn_pay_q + HDR_W + sz_q;
				end else if (count_q < CW'(MAX_EXTENTS)) begin
					if (idx_q == count_q) begin
						start_q[idx_i] <= fs_q;
						pay_q[idx_i] <= sz_q;
					end
					count_q <= count_q + 1'b1;
				end
			end
			if (cmd.shift) begin
				if (sh_dir_q) begin
					// open gap: move one entry up, walking down
					start_q[IW'(sh_q)] <= start_q[IW'(sh_q - 1'b1)];
					pay_q[IW'(sh_q)] <= pay_q[IW'(sh_q - 1'b1)];
					if (sh_q == sh_end_q + 1'b1) begin
						start_q[IW'(sh_end_q)] <= fs_q;
						pay_q[IW'(sh_end_q)] <= sz_q;
					end
				end else begin
					// close gap: move one entry down, walking up
					start_q[IW'(sh_q)] <= start_q[IW'(sh_q + 1'b1)];
					pay_q[IW'(sh_q)] <= pay_q[IW'(sh_q + 1'b1)];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			is_free_q <= req_type;
			bad_q <= bad_c;
			total_q <= {need[SW-1:ALB], {ALB{1'b0}}};
			fs_q <= fs_c;
			idx_q <= '0;
			found_q <= 1'b0;
			stop_q <= 1'b0;
			pick_q <= '0;
			res_st_q <= req_type ? ST_FREED : ST_NOFIT;
			res_off_q <= '0;
		end
		if (cmd.map_cap) begin
			sz_q <= AW'(map_rdata);
			if (bad_q) res_st_q <= ST_FREED;
		end
		if (cmd.scan && in_range && !stop_q) begin
			if (is_free_q) begin
				if (start_q[idx_i] > fs_q) stop_q <= 1'b1;
				else idx_q <= idx_q + 1'b1;
			end else begin
				if (SW'(pay_q[idx_i]) >= total_q && (!found_q || pay_q[idx_i] < pick_pay_q)) begin
					pick_q <= idx_i;
					pick_pay_q <= pay_q[idx_i];
					found_q <= 1'b1;
				end
				idx_q <= idx_q + 1'b1;
			end
		end
		if (cmd.look) begin
			up_st_q <= start_q[idx_i];
			up_pay_q <= pay_q[idx_i];
			dn_st_q <= start_q[IW'(idx_q - 1'b1)];
			dn_pay_q <= pay_q[IW'(idx_q - 1'b1)];
		end
		if (cmd.apply) begin
			if (!is_free_q) begin
				if (found_q) begin
					res_st_q <= ST_ALLOC;
					res_off_q <= 12'(start_q[pick_q] + HDR_W);
				end
			end else begin
				if (up_c && dn_c) begin
					sh_dir_q <= 1'b0;
					sh_q <= idx_q;
					sh_end_q <= count_q - 1'b1;
				end else if (!up_c && !dn_c) begin
					if (count_q >= CW'(MAX_EXTENTS)) res_st_q <= ST_FULL;
					sh_dir_q <= 1'b1;
					sh_q <= count_q;
					sh_end_q <= idx_q;
				end
			end
		end
		if (cmd.shift) sh_q <= sh_dir_q ? sh_q - 1'b1 : sh_q + 1'b1;
	end

	assign done = done_q;
	assign status = done_q ? res_st_q : '0;
	assign payload_offset = done_q ? res_off_q : '0;
endmodule

// ===== src/best_fit_heap_allocator_unit.sv =====
// Top level of the best-fit heap allocator: controller plus datapath.
// Depends on bfa_pkg, bfa_ctrl, bfa_dp, bfa_ram.
//
// Usage: drive req_type, alloc_bytes, free_offset and pulse start while busy
// is low; the request is taken at that edge. busy stays high until the
// result is shown. The result (status, payload_offset) appears for exactly
// one cycle with done high; the receiver cannot stall it.
// An allocate walks the free-extent table one entry per cycle and then shows
// its result. A free reads the block size map, walks to the insert point,
// then may shift the table one entry per cycle above that point before its
// result shows. A free offset out of range goes to its result without the
// walk. A new request can be taken in the cycle that shows the result. The
// table walk and shift set the rate.
// Reset (arst_n low) leaves one extent covering the arena less two headers;
// the block size map is undefined until written by an allocate.
// payload_offset is zero for every status other than allocated.
module best_fit_heap_allocator_unit import bfa_pkg::*; #(
	parameter int ARENA_BYTES  = 4096,
	parameter int ALIGN_BYTES  = 8,
	parameter int HEADER_BYTES = 8,
	parameter int MAX_EXTENTS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [12:0] alloc_bytes,
	input  logic [11:0] free_offset,
	output logic        done,
	output logic [1:0]  status,
	output logic [11:0] payload_offset
);
	bfa_cmd_t  cmd;
	bfa_stat_t st;

	bfa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .st(st), .cmd(cmd)
	);

	bfa_dp #(
		.ARENA_BYTES(ARENA_BYTES), .ALIGN_BYTES(ALIGN_BYTES),
		.HEADER_BYTES(HEADER_BYTES), .MAX_EXTENTS(MAX_EXTENTS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.req_type(req_type), .alloc_bytes(alloc_bytes), .free_offset(free_offset),
		.done(done), .status(status), .payload_offset(payload_offset)
	);
endmodule
